// ----- src/rmedf_pkg.sv -----
// Package with the shared types and constants of the tick scheduler.
`timescale 1ns / 1ps
`default_nettype none
package rmedf_pkg;

   typedef enum logic [1:0] {
      MODE_LOAD  = 2'd0,
      MODE_TICK  = 2'd1,
      MODE_FLUSH = 2'd2,
      MODE_STATS = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_FIN  = 2'd0,
      ST_PRE  = 2'd1,
      ST_LOST = 2'd2,
      ST_IDLE = 2'd3
   } seg_status_type;

   localparam logic CSR_POLICY = 1'b0;
   localparam logic CSR_COUNT  = 1'b1;

   typedef enum logic [3:0] {
      S_IDLE,
      S_LOAD,
      S_STATS,
      S_FLUSH,
      S_REL,
      S_KILL,
      S_PICK,
      S_RUN,
      S_END,
      S_EMIT
   } state_type;

   typedef struct packed {
      logic do_load;
      logic do_stats;
      logic do_flush;
      logic clr_idx;
      logic step_rel;
      logic step_kill;
      logic step_pick;
      logic do_run;
      logic do_end;
      logic pop;
   } cmd_type;

   typedef struct packed {
      logic idx_last;
      logic q_empty;
      logic q_one;
   } stat_type;

   typedef struct packed {
      logic        seg_valid;
      logic        seg_idle;
      logic [2:0]  seg_task;
      logic [31:0] seg_len;
      logic [1:0]  seg_status;
      logic [15:0] done_cnt;
      logic [15:0] lost_cnt;
      logic        killed;
      logic        rejected;
   } result_type;

endpackage
`default_nettype wire

// ----- src/rmedf_ctrl.sv -----
// Controller state machine that sequences one item through the datapath.
`timescale 1ns / 1ps
`default_nettype none
module rmedf_ctrl (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 start,
   input  wire [1:0]           mode,
   input  wire                 out_stall,
   input  rmedf_pkg::stat_type stat,
   output rmedf_pkg::cmd_type  cmd,
   output logic                busy,
   output logic                out_valid
);
   import rmedf_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               case (mode_type'(mode))
                  MODE_LOAD:  state_in = S_LOAD;
                  MODE_TICK:  state_in = S_REL;
                  MODE_FLUSH: state_in = S_FLUSH;
                  default:    state_in = S_STATS;
               endcase
            end
         end
         S_LOAD, S_STATS, S_FLUSH: state_in = S_EMIT;
         S_REL:  if (stat.idx_last) state_in = S_KILL;
         S_KILL: if (stat.idx_last) state_in = S_PICK;
         S_PICK: if (stat.idx_last) state_in = S_RUN;
         S_RUN:  state_in = S_END;
         S_END:  state_in = S_EMIT;
         S_EMIT: begin
            if (stat.q_empty) begin
               state_in = S_IDLE;
            end else if (!out_stall && stat.q_one) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      busy = 1'b1;
      out_valid = 1'b0;
      case (state_ff)
         S_IDLE: begin
            busy = 1'b0;
            cmd.clr_idx = 1'b1;
         end
         S_LOAD:  cmd.do_load = 1'b1;
         S_STATS: cmd.do_stats = 1'b1;
         S_FLUSH: cmd.do_flush = 1'b1;
         S_REL: begin
            cmd.step_rel = 1'b1;
            cmd.clr_idx = stat.idx_last;
         end
         S_KILL: begin
            cmd.step_kill = 1'b1;
            cmd.clr_idx = stat.idx_last;
         end
         S_PICK:  cmd.step_pick = 1'b1;
         S_RUN:   cmd.do_run = 1'b1;
         S_END:   cmd.do_end = 1'b1;
         S_EMIT: begin
            out_valid = !stat.q_empty;
            cmd.pop = !stat.q_empty && !out_stall;
         end
         default: busy = 1'b1;
      endcase
   end
endmodule
`default_nettype wire

// ----- src/rmedf_dp.sv -----
// Datapath: task tables, segment tracking and the result queue.
`timescale 1ns / 1ps
`default_nettype none
module rmedf_dp #(
   parameter int MAX_TASKS = 8
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   start,
   input  wire [2:0]             in_index,
   input  wire [15:0]            in_period,
   input  wire [15:0]            in_deadline,
   input  wire [15:0]            in_burst,
   input  wire                   csr_we,
   input  wire                   csr_sel,
   input  wire [31:0]            csr_data,
   input  rmedf_pkg::cmd_type    cmd,
   output rmedf_pkg::stat_type   stat,
   output rmedf_pkg::result_type rsp,
   output logic                  rsp_last
);
   import rmedf_pkg::*;

   localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int CW = $clog2(MAX_TASKS + 1);

   logic [15:0] per_ff [MAX_TASKS];
   logic [15:0] dl_ff  [MAX_TASKS];
   logic [15:0] bu_ff  [MAX_TASKS];
   logic [15:0] rem_ff [MAX_TASKS];
   logic [31:0] rel_ff [MAX_TASKS];
   logic [31:0] abs_ff [MAX_TASKS];
   logic [MAX_TASKS-1:0] act_ff;
   logic [15:0] done_ff [MAX_TASKS];
   logic [15:0] lost_ff [MAX_TASKS];

   logic        policy_ff;
   logic [3:0]  count_ff;
   logic [31:0] now_ff;
   logic        rv_ff;
   logic [IW-1:0] rt_ff;
   logic [31:0] rl_ff;
   logic        io_ff;

   logic [2:0]  idx3_ff;
   logic [15:0] pi_ff, di_ff, bi_ff;
   logic [IW-1:0] ix_ff;
   logic        found_ff;
   logic [IW-1:0] sel_ff;
   logic [31:0] best_ff;

   result_type  q_ff [3];
   logic [1:0]  qn_ff;
   logic [1:0]  qh_ff;

   logic [CW-1:0] cnt;
   logic          no_entries;
   logic          idx_ok;
   logic [IW-1:0] idxw;
   logic [31:0]   pr;
   logic          ready_i;
   logic          rel_due;
   logic          kill_due;
   logic          bad;
   result_type    load_res;
   result_type    stats_res;

   assign cnt = ({28'd0, count_ff} < 32'(MAX_TASKS)) ? CW'(count_ff) : CW'(MAX_TASKS);
   assign no_entries = (cnt == '0);
   assign stat.idx_last = no_entries || (CW'(ix_ff) == CW'(cnt - 1'b1));
   assign stat.q_empty = (qn_ff == 2'd0);
   assign stat.q_one = (qn_ff == 2'd1);
   assign idx_ok = (32'(idx3_ff) < 32'(MAX_TASKS));
   assign idxw = IW'(idx3_ff);

   assign rel_due  = !no_entries && (now_ff >= rel_ff[ix_ff]);
   assign kill_due = !no_entries && act_ff[ix_ff] && (now_ff >= abs_ff[ix_ff])
                     && (rem_ff[ix_ff] != 16'd0);
   assign ready_i  = !no_entries && act_ff[ix_ff] && (rem_ff[ix_ff] != 16'd0);
   assign pr = policy_ff ? abs_ff[ix_ff] : {16'd0, per_ff[ix_ff]};
   assign bad = (pi_ff == 0) || (di_ff == 0) || (bi_ff == 0) || (di_ff > pi_ff)
                || (bi_ff > di_ff) || !idx_ok;

   assign rsp = q_ff[qh_ff];
   assign rsp_last = (qn_ff == 2'd1);

   always_comb begin
      load_res = '0;
      load_res.rejected = bad;
      stats_res = '0;
      if (idx_ok) begin
         stats_res.done_cnt = done_ff[idxw];
         stats_res.lost_cnt = lost_ff[idxw];
         stats_res.killed = act_ff[idxw] && (rem_ff[idxw] != 16'd0);
      end
   end

   function automatic result_type seg(input logic idle, input logic [2:0] tk,
                                      input logic [31:0] len, input seg_status_type st);
      result_type r;
      r = '0;
      r.seg_valid = 1'b1;
      r.seg_idle = idle;
      r.seg_task = idle ? 3'd0 : tk;
      r.seg_len = len;
      r.seg_status = st;
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (start) begin
         idx3_ff <= in_index;
         pi_ff <= in_period;
         di_ff <= in_deadline;
         bi_ff <= in_burst;
      end
      if (cmd.clr_idx) begin
         ix_ff <= '0;
      end else if (cmd.step_rel || cmd.step_kill || cmd.step_pick) begin
         ix_ff <= IW'(ix_ff + 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff <= 1'b0;
         count_ff <= '0;
         now_ff <= '0;
         rv_ff <= 1'b0;
         rt_ff <= '0;
         rl_ff <= '0;
         io_ff <= 1'b0;
         act_ff <= '0;
         qn_ff <= '0;
         qh_ff <= '0;
         found_ff <= 1'b0;
         for (int i = 0; i < MAX_TASKS; i++) begin
            rem_ff[i] <= '0;
            rel_ff[i] <= '0;
            abs_ff[i] <= '0;
            done_ff[i] <= '0;
            lost_ff[i] <= '0;
         end
      end else begin
         if (csr_we) begin
            if (csr_sel == CSR_POLICY) begin
               policy_ff <= csr_data[0];
            end else begin
               count_ff <= csr_data[3:0];
            end
         end
         if (cmd.clr_idx && !cmd.step_rel && !cmd.step_kill) begin
            qh_ff <= '0;
            found_ff <= 1'b0;
         end
         if (cmd.pop) begin
            qn_ff <= qn_ff - 2'd1;
            qh_ff <= qh_ff + 2'd1;
         end
         if (cmd.do_load) begin
            q_ff[0] <= load_res;
            qn_ff <= 2'd1;
            if (!bad) begin
               per_ff[idxw] <= pi_ff;
               dl_ff[idxw] <= di_ff;
               bu_ff[idxw] <= bi_ff;
               rem_ff[idxw] <= bi_ff;
               rel_ff[idxw] <= now_ff;
               abs_ff[idxw] <= now_ff + {16'd0, di_ff};
               act_ff[idxw] <= 1'b1;
               done_ff[idxw] <= '0;
               lost_ff[idxw] <= '0;
            end
         end
         if (cmd.do_stats) begin
            q_ff[0] <= stats_res;
            qn_ff <= 2'd1;
         end
         if (cmd.do_flush) begin
            if (rv_ff && rl_ff != 0) begin
               q_ff[0] <= seg(1'b0, 3'(rt_ff), rl_ff,
                              (rem_ff[rt_ff] != 0) ? ST_PRE : ST_FIN);
               qn_ff <= 2'd1;
            end else if (io_ff && rl_ff != 0) begin
               q_ff[0] <= seg(1'b1, 3'd0, rl_ff, ST_IDLE);
               qn_ff <= 2'd1;
            end
            rv_ff <= 1'b0;
            io_ff <= 1'b0;
            rl_ff <= '0;
         end
         if (cmd.step_rel && !no_entries && rel_due) begin
            if (!act_ff[ix_ff]) begin
               act_ff[ix_ff] <= 1'b1;
               rem_ff[ix_ff] <= bu_ff[ix_ff];
               abs_ff[ix_ff] <= now_ff + {16'd0, dl_ff[ix_ff]};
            end
            rel_ff[ix_ff] <= rel_ff[ix_ff] + {16'd0, per_ff[ix_ff]};
         end
         if (cmd.step_kill && kill_due) begin
            if (rv_ff && rt_ff == ix_ff && rl_ff != 0) begin
               q_ff[qn_ff] <= seg(1'b0, 3'(ix_ff), rl_ff, ST_LOST);
               qn_ff <= qn_ff + 2'd1;
               rl_ff <= '0;
               rv_ff <= 1'b0;
               io_ff <= 1'b0;
            end
            if (lost_ff[ix_ff] != 16'hFFFF) lost_ff[ix_ff] <= lost_ff[ix_ff] + 16'd1;
            act_ff[ix_ff] <= 1'b0;
            rem_ff[ix_ff] <= '0;
         end
         if (cmd.step_pick && ready_i && (!found_ff || pr < best_ff)) begin
            found_ff <= 1'b1;
            sel_ff <= ix_ff;
            best_ff <= pr;
         end
         if (cmd.do_run) begin
            if (found_ff) begin
               if (!rv_ff || rt_ff != sel_ff) begin
                  if (rv_ff && rl_ff != 0) begin
                     q_ff[qn_ff] <= seg(1'b0, 3'(rt_ff), rl_ff,
                                        (rem_ff[rt_ff] != 0) ? ST_PRE : ST_FIN);
                     qn_ff <= qn_ff + 2'd1;
                     rl_ff <= 32'd1;
                  end else if (io_ff && rl_ff != 0) begin
                     q_ff[qn_ff] <= seg(1'b1, 3'd0, rl_ff, ST_IDLE);
                     qn_ff <= qn_ff + 2'd1;
                     rl_ff <= 32'd1;
                     io_ff <= 1'b0;
                  end else begin
                     rl_ff <= (rl_ff != 32'hFFFFFFFF) ? rl_ff + 32'd1 : rl_ff;
                  end
                  rv_ff <= 1'b1;
                  rt_ff <= sel_ff;
               end else begin
                  rl_ff <= (rl_ff != 32'hFFFFFFFF) ? rl_ff + 32'd1 : rl_ff;
               end
               rem_ff[sel_ff] <= rem_ff[sel_ff] - 16'd1;
            end else begin
               if (rv_ff) begin
                  if (rl_ff != 0) begin
                     q_ff[qn_ff] <= seg(1'b0, 3'(rt_ff), rl_ff,
                                        (rem_ff[rt_ff] != 0) ? ST_PRE : ST_FIN);
                     qn_ff <= qn_ff + 2'd1;
                  end
                  rv_ff <= 1'b0;
               end
               if (!io_ff || rv_ff) begin
                  io_ff <= 1'b1;
                  rl_ff <= 32'd1;
               end else if (rl_ff != 32'hFFFFFFFF) begin
                  rl_ff <= rl_ff + 32'd1;
               end
            end
            now_ff <= now_ff + 32'd1;
         end
         if (cmd.do_end && found_ff && rem_ff[sel_ff] == 16'd0) begin
            if (done_ff[sel_ff] != 16'hFFFF) done_ff[sel_ff] <= done_ff[sel_ff] + 16'd1;
            act_ff[sel_ff] <= 1'b0;
            q_ff[qn_ff] <= seg(1'b0, 3'(sel_ff), rl_ff, ST_FIN);
            qn_ff <= qn_ff + 2'd1;
            rl_ff <= '0;
            rv_ff <= 1'b0;
         end
      end
   end
endmodule
`default_nettype wire

// ----- src/rm_edf_tick_scheduler_unit.sv -----
// Top level of the periodic task scheduler with rate monotonic and EDF policies.
//
//  channel  direction  handshake        carries
//  req_     in         valid / stall    mode, task index, period, deadline, burst
//  rsp_     out        valid / stall    segment record, stats or load status
//  csr_     in         valid / ready    register index and write data
//
// A load, flush or stats item runs its own step and then emits its results, if any.
// A tick walks the task table three times, to release, kill and pick, one entry a cycle;
// then it runs the picked task or idles, retires a finished task and emits the results.
// Reset clears all control state; the task tables hold nothing until loaded.
// A stalled result holds the block; the next item is taken once all results leave.
`timescale 1ns / 1ps
`default_nettype none
module rm_edf_tick_scheduler_unit #(
   parameter int MAX_TASKS = 8
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [1:0]  req_mode,
   input  wire  [2:0]  req_task_index,
   input  wire  [15:0] req_task_period,
   input  wire  [15:0] req_task_deadline,
   input  wire  [15:0] req_task_burst,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic        rsp_segment_valid,
   output logic        rsp_segment_idle,
   output logic [2:0]  rsp_segment_task,
   output logic [31:0] rsp_segment_length,
   output logic [1:0]  rsp_segment_status,
   output logic [15:0] rsp_completed_count,
   output logic [15:0] rsp_missed_count,
   output logic        rsp_killed,
   output logic        rsp_load_rejected,
   output logic        rsp_last,
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [0:0]  csr_index,
   input  wire  [31:0] csr_data
);
   import rmedf_pkg::*;

   cmd_type    cmd;
   stat_type   stat;
   result_type res;
   logic       busy;
   logic       start;

   assign req_stall = busy;
   assign start = req_valid && !busy;
   assign csr_ready = 1'b1;

   rmedf_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .mode(req_mode),
      .out_stall(rsp_stall), .stat(stat), .cmd(cmd), .busy(busy), .out_valid(rsp_valid)
   );

   rmedf_dp #(.MAX_TASKS(MAX_TASKS)) u_dp (
      .clock(clock), .reset(reset), .start(start), .in_index(req_task_index),
      .in_period(req_task_period), .in_deadline(req_task_deadline),
      .in_burst(req_task_burst), .csr_we(csr_valid), .csr_sel(csr_index[0]),
      .csr_data(csr_data), .cmd(cmd), .stat(stat), .rsp(res), .rsp_last(rsp_last)
   );

   assign rsp_segment_valid = res.seg_valid;
   assign rsp_segment_idle = res.seg_idle;
   assign rsp_segment_task = res.seg_task;
   assign rsp_segment_length = res.seg_len;
   assign rsp_segment_status = res.seg_status;
   assign rsp_completed_count = res.done_cnt;
   assign rsp_missed_count = res.lost_cnt;
   assign rsp_killed = res.killed;
   assign rsp_load_rejected = res.rejected;
endmodule
`default_nettype wire
